/* rtl/bsp_pkg.sv */
// Package for the billboard sprite projection block.
// Holds fixed-point formats, datapath widths and register indexes.
// No dependencies.
package bsp_pkg;

  // Fixed-point formats of the input words
  localparam int COORD_FRAC_BITS = 8;
  localparam int VEC_FRAC_BITS   = 14;

  // Depth test: depth > 0.1  <=>  10 * b * 2^V > det * 2^C
  localparam int DEPTH_SHIFT = VEC_FRAC_BITS - COORD_FRAC_BITS;
  localparam int DEPTH_RATIO = 10 << DEPTH_SHIFT;

  // Divider widths: numerators below 2^46, divisors below 2^39,
  // quotients needed to 17 bits (sx saturates past that)
  localparam int NUM_W   = 46;
  localparam int DEN_W   = 39;
  localparam int Q_W     = 17;
  localparam int CMP_W   = DEN_W + Q_W;
  localparam int DIV_LAT = Q_W + 1;

  // Configuration registers
  localparam int SCR_W = 13;
  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

endpackage

/* rtl/bsp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bsp_pkg. Stage 0 registers the operands and the overflow flag.
module bsp_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bsp_pkg::NUM_W-1:0] num_i,
  input  logic [bsp_pkg::DEN_W-1:0] den_i,
  output logic [bsp_pkg::Q_W-1:0]   quo_o,
  output logic                      ovf_o
);
  import bsp_pkg::*;

  logic [NUM_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             ovf_q [Q_W+1];

  logic [NUM_W-1:0] rem_d [Q_W];
  logic [Q_W-1:0]   quo_d [Q_W];
  logic             ovf_d;

  // overflow: quotient would not fit in Q_W bits
  always_comb begin
    ovf_d = ({{(CMP_W-NUM_W){1'b0}}, num_i} >=
             ({{(CMP_W-DEN_W){1'b0}}, den_i} << Q_W));
  end

  // one compare and subtract per stage
  always_comb begin
    logic [CMP_W-1:0] shd;
    logic             fits;
    for (int k = 0; k < Q_W; k++) begin
      shd  = {{(CMP_W-DEN_W){1'b0}}, den_q[k]} << (Q_W-1-k);
      fits = ({{(CMP_W-NUM_W){1'b0}}, rem_q[k]} >= shd);
      rem_d[k] = fits ? (rem_q[k] - shd[NUM_W-1:0]) : rem_q[k];
      quo_d[k] = quo_q[k];
      quo_d[k][Q_W-1-k] = fits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k+1] <= rem_d[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_d[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[Q_W];
  assign ovf_o = ovf_q[Q_W];

endmodule

/* rtl/billboard_sprite_projection.sv */
// Billboard sprite projection: camera-space transform, depth test,
// pipelined divides for column and size, then screen clamping.
// Throughput: one word per cycle; the whole pipe holds while the output
// word is stalled. Reset clears valid bits and sets 640x480 screen size.
module billboard_sprite_projection (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bsp_pkg::SCR_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      active_i,
  input  logic signed [15:0]        sprite_x_i,
  input  logic signed [15:0]        sprite_y_i,
  input  logic signed [15:0]        viewer_x_i,
  input  logic signed [15:0]        viewer_y_i,
  input  logic signed [15:0]        facing_x_i,
  input  logic signed [15:0]        facing_y_i,
  input  logic signed [15:0]        lens_x_i,
  input  logic signed [15:0]        lens_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      visible_o,
  output logic [11:0]               left_x_o,
  output logic [11:0]               top_y_o,
  output logic [15:0]               box_width_o,
  output logic [15:0]               box_height_o
);
  import bsp_pkg::*;

  typedef struct packed {
    logic hide;
    logic neg;
  } side_t;

  logic en;
  logic [SCR_W-1:0] scr_w_q, scr_h_q;

  // pipe advances unless the output word is held
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_WIDTH_RESET;
      scr_h_q <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SCREEN_WIDTH)  scr_w_q <= cfg_data_i;
      if (cfg_idx_i == REG_SCREEN_HEIGHT) scr_h_q <= cfg_data_i;
    end
  end

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic sv_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) sv_q[k] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q;
      sv_q[0] <= v6_q;
      for (int k = 1; k < DIV_LAT; k++) sv_q[k] <= sv_q[k-1];
      out_valid_o <= sv_q[DIV_LAT-1];
    end
  end

  // payload stages
  logic act1_q, act2_q, act3_q;
  logic signed [16:0] rx1_q, ry1_q;
  logic signed [15:0] fx1_q, fy1_q, lx1_q, ly1_q;
  logic signed [31:0] pdf_q, pdg_q;
  logic signed [32:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [32:0] det3_q;
  logic signed [33:0] a3_q, b3_q;
  logic               hide4_q, hide5_q, hide6_q;
  logic signed [32:0] det4_q;
  logic signed [34:0] a4_q, b4_q;
  logic signed [44:0] deep;
  logic signed [35:0] s5_q;
  logic signed [32:0] det5_q;
  logic signed [34:0] b5_q;
  logic [35:0]        smag;
  logic               neg6_q;
  logic [NUM_W-1:0]   num_sx_q, num_sz_q;
  logic [DEN_W-1:0]   den_sx_q, den_sz_q;
  side_t              sd_q [DIV_LAT];

  assign deep = 45'(b4_q) * 45'(DEPTH_RATIO);
  assign smag = s5_q[35] ? 36'(-s5_q) : 36'(s5_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // offset from viewer
      act1_q <= active_i;
      rx1_q  <= 17'(sprite_x_i) - 17'(viewer_x_i);
      ry1_q  <= 17'(sprite_y_i) - 17'(viewer_y_i);
      fx1_q  <= facing_x_i; fy1_q <= facing_y_i;
      lx1_q  <= lens_x_i;   ly1_q <= lens_y_i;
      // products
      act2_q <= act1_q;
      pdf_q  <= lx1_q * fy1_q;
      pdg_q  <= fx1_q * ly1_q;
      pa1_q  <= fy1_q * rx1_q;
      pa2_q  <= fx1_q * ry1_q;
      pb1_q  <= lx1_q * ry1_q;
      pb2_q  <= ly1_q * rx1_q;
      // determinant and camera coordinates
      act3_q <= act2_q;
      det3_q <= 33'(pdf_q) - 33'(pdg_q);
      a3_q   <= 34'(pa1_q) - 34'(pa2_q);
      b3_q   <= 34'(pb1_q) - 34'(pb2_q);
      // sign normalization
      hide4_q <= !act3_q || (det3_q == '0);
      det4_q  <= det3_q[32] ? -det3_q : det3_q;
      a4_q    <= det3_q[32] ? -35'(a3_q) : 35'(a3_q);
      b4_q    <= det3_q[32] ? -35'(b3_q) : 35'(b3_q);
      // depth test
      hide5_q <= hide4_q || (b4_q <= 0) || (deep <= 45'(det4_q));
      s5_q    <= 36'(a4_q) + 36'(b4_q);
      det5_q  <= det4_q;
      b5_q    <= b4_q;
      // divider operands
      hide6_q  <= hide5_q;
      neg6_q   <= s5_q[35];
      num_sx_q <= NUM_W'(scr_w_q[SCR_W-1:1]) * NUM_W'(smag[33:0]);
      num_sz_q <= NUM_W'(scr_h_q) * NUM_W'(det5_q[31:0]);
      den_sx_q <= DEN_W'(b5_q[32:0]);
      den_sz_q <= {b5_q[32:0], {DEPTH_SHIFT{1'b0}}};
      // side data alongside the dividers
      sd_q[0] <= '{hide: hide6_q, neg: neg6_q};
      for (int k = 1; k < DIV_LAT; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // column and size dividers
  logic [Q_W-1:0] q_sx, q_sz;
  logic           ovf_sx, ovf_sz;

  bsp_div u_div_sx (
    .clk_i (clk_i), .en_i (en), .num_i (num_sx_q), .den_i (den_sx_q),
    .quo_o (q_sx), .ovf_o (ovf_sx)
  );

  bsp_div u_div_sz (
    .clk_i (clk_i), .en_i (en), .num_i (num_sz_q), .den_i (den_sz_q),
    .quo_o (q_sz), .ovf_o (ovf_sz)
  );

  // clamp to the screen and decide visibility
  logic [Q_W-1:0]     mag_sx;
  logic signed [19:0] sx, hs, hh, w20, h20;
  logic signed [19:0] sx0, sx1, sy0, sy1;
  logic               vis;

  always_comb begin
    mag_sx = ovf_sx ? '1 : q_sx;
    sx  = sd_q[DIV_LAT-1].neg ? -20'(mag_sx) : 20'(mag_sx);
    hs  = 20'(q_sz[Q_W-1:1]);
    hh  = 20'(scr_h_q[SCR_W-1:1]);
    w20 = 20'(scr_w_q);
    h20 = 20'(scr_h_q);
    sy0 = hh - hs;
    if (sy0 < 0) sy0 = '0;
    sy1 = hh + hs;
    if (sy1 >= h20) sy1 = h20 - 20'sd1;
    sx0 = sx - hs;
    if (sx0 < 0) sx0 = '0;
    sx1 = sx + hs;
    if (sx1 >= w20) sx1 = w20 - 20'sd1;
    vis = !sd_q[DIV_LAT-1].hide && !ovf_sz &&
          (sx0 < w20) && (sx1 >= 0) && (sy0 < h20) && (sy1 >= 0);
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_o <= vis;
      if (vis) begin
        left_x_o     <= (sx0 > 20'sd4095) ? 12'hFFF : sx0[11:0];
        top_y_o      <= (sy0 > 20'sd4095) ? 12'hFFF : sy0[11:0];
        box_width_o  <= q_sz[Q_W-1] ? 16'hFFFF : q_sz[15:0];
        box_height_o <= q_sz[Q_W-1] ? 16'hFFFF : q_sz[15:0];
      end else begin
        left_x_o     <= '0;
        top_y_o      <= '0;
        box_width_o  <= '0;
        box_height_o <= '0;
      end
    end
  end

  // checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input held without a blocked output word");

  a_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && visible_o) |-> (box_width_o == box_height_o))
    else $error("projected box not square");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |->
      (left_x_o == '0 && top_y_o == '0 && box_width_o == '0))
    else $error("hidden word carries nonzero fields");

endmodule

/* tb/bsp_checker.sv */
// Checker for the billboard sprite projection block: watches the input and
// output channels, predicts each result from the accepted word and compares.
// Depends on bsp_pkg for the screen register width.
module bsp_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bsp_pkg::SCR_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      active_i,
  input  logic signed [15:0]        sprite_x_i,
  input  logic signed [15:0]        sprite_y_i,
  input  logic signed [15:0]        viewer_x_i,
  input  logic signed [15:0]        viewer_y_i,
  input  logic signed [15:0]        facing_x_i,
  input  logic signed [15:0]        facing_y_i,
  input  logic signed [15:0]        lens_x_i,
  input  logic signed [15:0]        lens_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      visible_i,
  input  logic [11:0]               left_x_i,
  input  logic [11:0]               top_y_i,
  input  logic [15:0]               box_width_i,
  input  logic [15:0]               box_height_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        seen_visible_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsp_pkg::*;

  typedef struct packed {
    logic        visible;
    logic [11:0] left_x;
    logic [11:0] top_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
  } rect_t;

  logic [SCR_W-1:0] scr_w_q, scr_h_q;
  rect_t            rect_q[$];

  // Exact integer projection of one sprite onto the screen
  function automatic rect_t project_sprite(
    input logic act,
    input logic signed [15:0] spx, spy, vwx, vwy, fcx, fcy, lnx, lny);
    longint rx, ry, det, a, b, w, h, sx, sz, hs, y0, y1, x0, x1;
    rect_t r;
    r = '0;
    if (!act) return r;
    rx  = longint'(spx) - longint'(vwx);
    ry  = longint'(spy) - longint'(vwy);
    det = longint'(lnx) * fcy - longint'(fcx) * lny;
    if (det == 0) return r;
    a = longint'(fcy) * rx - longint'(fcx) * ry;
    b = longint'(lnx) * ry - longint'(lny) * rx;
    if (det < 0) begin
      det = -det; a = -a; b = -b;
    end
    // depth must exceed one tenth
    if (b <= 0 || 10 * b * (64'sd1 <<< VEC_FRAC_BITS) <= det * (64'sd1 <<< COORD_FRAC_BITS))
      return r;
    w  = longint'(scr_w_q);
    h  = longint'(scr_h_q);
    sx = ((w / 2) * (a + b)) / b;
    sz = (h * det * (64'sd1 <<< COORD_FRAC_BITS)) / (b * (64'sd1 <<< VEC_FRAC_BITS));
    hs = sz / 2;
    y0 = h / 2 - hs; if (y0 < 0) y0 = 0;
    y1 = h / 2 + hs; if (y1 >= h) y1 = h - 1;
    x0 = sx - hs;    if (x0 < 0) x0 = 0;
    x1 = sx + hs;    if (x1 >= w) x1 = w - 1;
    if (!(x0 < w && x1 >= 0 && y0 < h && y1 >= 0)) return r;
    if (x0 > 4095) x0 = 4095;
    if (y0 > 4095) y0 = 4095;
    if (sz > 65535) sz = 65535;
    r.visible = 1'b1;
    r.left_x  = x0[11:0];
    r.top_y   = y0[11:0];
    r.box_w   = sz[15:0];
    r.box_h   = sz[15:0];
    return r;
  endfunction

  assign pending_o = rect_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rect_t got, want;
    if (!rst_ni) begin
      scr_w_q        <= SCREEN_WIDTH_RESET;
      scr_h_q        <= SCREEN_HEIGHT_RESET;
      fail_count_o   <= 0;
      seen_visible_o <= 0;
      rect_q.delete();
    end else begin
      // output word against oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = {visible_i, left_x_i, top_y_i, box_width_i, box_height_i};
        if (got.visible) seen_visible_o <= seen_visible_o + 1;
        if (rect_q.size() == 0) begin
          $display("%0t: unexpected word vis=%0d x=%0d y=%0d w=%0d h=%0d", $time,
                   got.visible, got.left_x, got.top_y, got.box_w, got.box_h);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rect_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch exp vis=%0d x=%0d y=%0d w=%0d h=%0d",
                     $time, want.visible, want.left_x, want.top_y, want.box_w, want.box_h);
            $display("%0t:          act vis=%0d x=%0d y=%0d w=%0d h=%0d",
                     $time, got.visible, got.left_x, got.top_y, got.box_w, got.box_h);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // input word: predict with current screen size
      if (in_valid_i && !in_stall_i)
        rect_q.push_back(project_sprite(active_i, sprite_x_i, sprite_y_i, viewer_x_i,
                                        viewer_y_i, facing_x_i, facing_y_i,
                                        lens_x_i, lens_y_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SCREEN_WIDTH) scr_w_q <= cfg_data_i;
        else                               scr_h_q <= cfg_data_i;
      end
    end
  end
endmodule

/* tb/tb_billboard_sprite_projection.sv */
// Testbench top for billboard_sprite_projection: drives directed and random
// sprites over several screen sizes; bsp_checker does prediction and compare.
// Depends on bsp_pkg, the RTL and tb/bsp_checker.sv.
module tb_billboard_sprite_projection;
  timeunit 1ns;
  timeprecision 1ps;
  import bsp_pkg::*;

  localparam int LATENCY = 25;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = REG_SCREEN_WIDTH;
  logic [SCR_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              active = 1'b0;
  logic signed [15:0] spx = '0, spy = '0, vwx = '0, vwy = '0;
  logic signed [15:0] fcx = '0, fcy = '0, lnx = '0, lny = '0;
  logic              out_valid, out_stall = 1'b0;
  logic              visible;
  logic [11:0]       left_x, top_y;
  logic [15:0]       box_w, box_h;
  int                fail_count, pending, seen_visible;
  int                sprites_sent = 0;
  bit                hold_long = 1'b0;
  bit                quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  billboard_sprite_projection uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .active_i(active),
    .sprite_x_i(spx), .sprite_y_i(spy), .viewer_x_i(vwx), .viewer_y_i(vwy),
    .facing_x_i(fcx), .facing_y_i(fcy), .lens_x_i(lnx), .lens_y_i(lny),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .visible_o(visible),
    .left_x_o(left_x), .top_y_o(top_y), .box_width_o(box_w), .box_height_o(box_h)
  );

  bsp_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .active_i(active),
    .sprite_x_i(spx), .sprite_y_i(spy), .viewer_x_i(vwx), .viewer_y_i(vwy),
    .facing_x_i(fcx), .facing_y_i(fcy), .lens_x_i(lnx), .lens_y_i(lny),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .visible_i(visible),
    .left_x_i(left_x), .top_y_i(top_y), .box_width_i(box_w), .box_height_i(box_h),
    .fail_count_o(fail_count), .pending_o(pending), .seen_visible_o(seen_visible)
  );

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_sprite(input logic act,
                             input logic signed [15:0] a, b, c, d, e, f, g, h);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    active <= act;
    spx <= a; spy <= b; vwx <= c; vwy <= d;
    fcx <= e; fcy <= f; lnx <= g; lny <= h;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sprites_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_screen(input logic idx, input logic [SCR_W-1:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random sprite: mostly a sane camera with nearby sprites, some raw noise
  task automatic random_sprite();
    logic signed [15:0] v[8];
    int ang;
    for (int i = 0; i < 8; i++) v[i] = 16'($urandom());
    if ($urandom_range(0, 9) < 7) begin
      v[2] = 16'($signed($urandom_range(0, 8192)) - 4096);
      v[3] = 16'($signed($urandom_range(0, 8192)) - 4096);
      v[0] = v[2] + 16'($signed($urandom_range(0, 4096)) - 2048);
      v[1] = v[3] + 16'($signed($urandom_range(0, 4096)) - 2048);
      ang = $urandom_range(0, 3);
      case (ang)
        0: begin v[4] = 16'sd16384;  v[5] = 0; v[6] = 0; v[7] = 16'sd10813; end
        1: begin v[4] = 0; v[5] = 16'sd16384;  v[6] = -16'sd10813; v[7] = 0; end
        2: begin v[4] = -16'sd11585; v[5] = 16'sd11585; v[6] = -16'sd7646;
                 v[7] = -16'sd7646; end
        default: begin
          v[4] = 16'($signed($urandom_range(0, 32767)) - 16384);
          v[5] = 16'($signed($urandom_range(0, 32767)) - 16384);
          v[6] = -(v[5] >>> 1); v[7] = v[4] >>> 1;
        end
      endcase
    end
    send_sprite($urandom_range(0, 15) != 0, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  initial begin
    logic [SCR_W-1:0] widths[6]  = '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd320};
    logic [SCR_W-1:0] heights[6] = '{13'd480, 13'd4096, 13'd1, 13'd8191, 13'd200, 13'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: inactive, zero determinant, behind, too near, huge, extremes
    send_sprite(1'b0, 16'sd512, 0, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd512, 0, 0, 0, 0, 0, 0, 0);
    send_sprite(1'b1, 16'sd512, 0, 0, 0, 16'sd16384, 0, 16'sd16384, 0);
    send_sprite(1'b1, -16'sd512, 0, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd10, 0, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd27, 0, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd512, 0, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd512, 16'sd300, 0, 0, 16'sd16384, 0, 0, 16'sd10813);
    send_sprite(1'b1, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_sprite(1'b1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_sprite(1'b1, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                16'sd1, 0, 0, 16'sd1);
    send_sprite(1'b1, 16'sd300, 0, 0, 0, 16'sd1, 0, 0, -16'sd32768);
    send_sprite(1'b1, 16'sd30, 0, 0, 0, -16'sd32768, 0, 0, 16'sd32767);
    send_sprite(1'b1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd1);
    drain_pipe();

    // Phases over screen sizes, including zero and the 13-bit extremes
    for (int p = 0; p < 6; p++) begin
      write_screen(REG_SCREEN_WIDTH, widths[p]);
      write_screen(REG_SCREEN_HEIGHT, heights[p]);
      if (p == 5) quiet = 1'b1;
      if (p == 1) hold_long = 1'b1;
      for (int i = 0; i < 300; i++) random_sprite();
      drain_pipe();
    end

    $display("Sent %0d sprites over 6 screen sizes; %0d came back visible.",
             sprites_sent, seen_visible);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule

/* filelist.f */
rtl/bsp_pkg.sv
rtl/bsp_div.sv
rtl/billboard_sprite_projection.sv
tb/bsp_checker.sv
tb/tb_billboard_sprite_projection.sv
